/* rtl/core/quaternion_to_euler_top_assert.svh */
// assertion macros for the quaternion to euler block
`ifndef QUATERNION_TO_EULER_TOP_ASSERT_SVH
`define QUATERNION_TO_EULER_TOP_ASSERT_SVH

// same-cycle implication, checked on every rising edge outside reset
`define QTE_ASSERT_IMP(name, ante, cons, msg) \
  name: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error(msg);

// next-cycle implication
`define QTE_ASSERT_NXT(name, ante, cons, msg) \
  name: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error(msg);

`endif

/* rtl/core/qte_pkg.sv */
// shared types, widths and arctangent table for the quaternion to euler block
package qte_pkg;

  localparam int COMPONENT_WIDTH = 16;
  localparam int ANGLE_WIDTH     = 16;
  localparam int CORDIC_STEPS    = 30;
  // pre-rotation register, one register per step, rounding register
  localparam int CORDIC_LAT      = CORDIC_STEPS + 2;

  localparam int PROD_SHIFT  = (2 * COMPONENT_WIDTH > 32) ? (2 * COMPONENT_WIDTH - 32) : 0;
  localparam int PROD_WIDTH  = 2 * COMPONENT_WIDTH - PROD_SHIFT;
  localparam int OPND_WIDTH  = PROD_WIDTH + 1;
  localparam int ROOT_WIDTH  = PROD_WIDTH - 2;
  localparam int ACC_WIDTH   = 34;

  // atan(2^-i) with pi = 2^31
  localparam logic [31:0] ATAN_TAB [CORDIC_STEPS] = '{
    32'h20000000, 32'h12E4051E, 32'h09FB385B, 32'h051111D4, 32'h028B0D43,
    32'h0145D7E1, 32'h00A2F61E, 32'h00517C55, 32'h0028BE53, 32'h00145F2F,
    32'h000A2F98, 32'h000517CC, 32'h00028BE6, 32'h000145F3, 32'h0000A2FA,
    32'h0000517D, 32'h000028BE, 32'h0000145F, 32'h00000A30, 32'h00000518,
    32'h0000028C, 32'h00000146, 32'h000000A3, 32'h00000051, 32'h00000029,
    32'h00000014, 32'h0000000A, 32'h00000005, 32'h00000003, 32'h00000001
  };

  typedef struct packed {
    logic signed [COMPONENT_WIDTH-1:0] q_w;
    logic signed [COMPONENT_WIDTH-1:0] q_x;
    logic signed [COMPONENT_WIDTH-1:0] q_y;
    logic signed [COMPONENT_WIDTH-1:0] q_z;
  } quat_t;

  typedef struct packed {
    logic signed [ANGLE_WIDTH-1:0] roll_angle;
    logic signed [ANGLE_WIDTH-1:0] pitch_angle;
    logic signed [ANGLE_WIDTH-1:0] yaw_angle;
  } euler_t;

endpackage

/* rtl/core/qte_delay.sv */
// enabled shift line that keeps side data in step with the pipeline
module qte_delay import qte_pkg::*; #(
  parameter int WIDTH = 1,
  parameter int DEPTH = CORDIC_LAT
) (
  input  logic             clk,
  input  logic             rst,
  input  logic             en,
  input  logic [WIDTH-1:0] d,
  output logic [WIDTH-1:0] q
);

  logic [WIDTH-1:0] stg [DEPTH];

  always_ff @(posedge clk) begin
    if (rst) begin
      for (int i = 0; i < DEPTH; i++) stg[i] <= '0;
    end else if (en) begin
      stg[0] <= d;
      for (int i = 1; i < DEPTH; i++) stg[i] <= stg[i-1];
    end
  end

  assign q = stg[DEPTH-1];

endmodule

/* rtl/core/qte_isqrt.sv */
// pipelined integer square root, one root bit per stage, rounding down
module qte_isqrt import qte_pkg::*; #(
  parameter int ROOT_W = ROOT_WIDTH
) (
  input  logic                  clk,
  input  logic                  en,
  input  logic [2*ROOT_W-1:0]   rad,
  output logic [ROOT_W-1:0]     root
);

  localparam int RW = ROOT_W + 2;

  logic [RW-1:0]       rem [ROOT_W-1];
  logic [2*ROOT_W-1:0] rd  [ROOT_W-1];
  logic [ROOT_W-1:0]   q   [ROOT_W];

  for (genvar k = 0; k < ROOT_W; k++) begin : g_stage
    logic [RW-1:0]       rem_prev;
    logic [ROOT_W-1:0]   q_prev;
    logic [2*ROOT_W-1:0] rd_prev;
    logic [RW-1:0]       shifted;
    logic [RW-1:0]       trial;
    logic [RW-1:0]       diff;
    logic                ge;

    if (k == 0) begin : g_first
      assign rem_prev = '0;
      assign q_prev   = '0;
      assign rd_prev  = rad;
    end else begin : g_rest
      assign rem_prev = rem[k-1];
      assign q_prev   = q[k-1];
      assign rd_prev  = rd[k-1];
    end

    // remainder stays below 2^ROOT_W until the last stage, so the top bits drop safely
    assign shifted = {rem_prev[RW-3:0], rd_prev[2*ROOT_W-1 -: 2]};
    assign trial   = {q_prev, 2'b01};
    assign ge      = (shifted >= trial);
    assign diff    = shifted - trial;

    always_ff @(posedge clk) begin
      if (en) begin
        q[k] <= {q_prev[ROOT_W-2:0], ge};
      end
    end

    if (k < ROOT_W - 1) begin : g_carry
      always_ff @(posedge clk) begin
        if (en) begin
          rem[k] <= ge ? diff : shifted;
          rd[k]  <= rd_prev << 2;
        end
      end
    end
  end

  assign root = q[ROOT_W-1];

endmodule

/* rtl/core/qte_cordic.sv */
// pipelined cordic vectoring unit giving atan2 as a rounded binary angle
module qte_cordic import qte_pkg::*; #(
  parameter int OPND_W = OPND_WIDTH,
  parameter int ANG_W  = ANGLE_WIDTH
) (
  input  logic                     clk,
  input  logic                     en,
  input  logic signed [OPND_W-1:0] y_in,
  input  logic signed [OPND_W-1:0] x_in,
  output logic [ANG_W-1:0]         angle
);

  localparam int CW = OPND_W + 2;
  localparam int ZW = ACC_WIDTH;
  localparam int N  = CORDIC_STEPS;
  localparam logic signed [ZW-1:0] Z_QUARTER = ZW'(2**30);

  logic signed [CW-1:0] xs [N+1];
  logic signed [CW-1:0] ys [N+1];
  logic signed [ZW-1:0] zs [N+1];
  logic                 zflag [N+1];

  logic signed [CW-1:0] xe, ye, x0, y0;
  logic signed [ZW-1:0] z0;
  logic [ANG_W-1:0]     rounded;

  assign xe = CW'(x_in);
  assign ye = CW'(y_in);

  // turn a left-half vector by a quarter turn so the iterations converge
  always_comb begin
    if (xe < 0) begin
      if (ye >= 0) begin
        x0 = ye;
        y0 = -xe;
        z0 = Z_QUARTER;
      end else begin
        x0 = -ye;
        y0 = xe;
        z0 = -Z_QUARTER;
      end
    end else begin
      x0 = xe;
      y0 = ye;
      z0 = '0;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      xs[0]    <= x0;
      ys[0]    <= y0;
      zs[0]    <= z0;
      zflag[0] <= (x_in == '0) && (y_in == '0);
    end
  end

  for (genvar i = 0; i < N; i++) begin : g_step
    always_ff @(posedge clk) begin
      if (en) begin
        if (ys[i] > 0) begin
          xs[i+1] <= xs[i] + (ys[i] >>> i);
          ys[i+1] <= ys[i] - (xs[i] >>> i);
          zs[i+1] <= zs[i] + ZW'(ATAN_TAB[i]);
        end else begin
          xs[i+1] <= xs[i] - (ys[i] >>> i);
          ys[i+1] <= ys[i] + (xs[i] >>> i);
          zs[i+1] <= zs[i] - ZW'(ATAN_TAB[i]);
        end
        zflag[i+1] <= zflag[i];
      end
    end
  end

  // round to nearest, ties upward, then wrap
  if (ANG_W < 32) begin : g_round
    logic signed [ZW-1:0] z_sum;
    assign z_sum   = zs[N] + ZW'(2**(31 - ANG_W));
    assign rounded = ANG_W'(z_sum >>> (32 - ANG_W));
  end else begin : g_exact
    assign rounded = zs[N][ANG_W-1:0];
  end

  always_ff @(posedge clk) begin
    if (en) begin
      angle <= zflag[N] ? '0 : rounded;
    end
  end

endmodule

/* rtl/core/quaternion_to_euler_top.sv */
// Quaternion to ZYX Euler angles. One quaternion is taken per clock unless stalled, and
// every transfer yields one roll/pitch/yaw triple via 4 product and sum stages, a 30-stage
// square root and a 32-stage cordic; the three cordic units and the square root are fully
// pipelined, so the block sustains one item per cycle unless held. A two-entry output
// register keeps quat_ready a registered signal: it drops only once a stalled result
// fills the skid slot, and then the whole pipeline holds until euler_ready frees it.
`include "quaternion_to_euler_top_assert.svh"

module quaternion_to_euler_top import qte_pkg::*; (
  input  logic   clk,
  input  logic   rst,
  input  logic   quat_valid,
  output logic   quat_ready,
  input  quat_t  quat,
  output logic   euler_valid,
  input  logic   euler_ready,
  output euler_t euler
);

  localparam int W        = COMPONENT_WIDTH;
  localparam int A        = ANGLE_WIDTH;
  localparam int P        = PROD_WIDTH;
  localparam int OW       = OPND_WIDTH;
  localparam int NB       = ROOT_WIDTH;
  localparam int TW       = P - 3;
  localparam int ALIGN    = 2 + NB;
  localparam int PIPE_LAT = 4 + NB + CORDIC_LAT;

  localparam logic signed [OW-1:0] HALF_VAL  = OW'(1) << (P - 3);
  localparam logic [2*NB-1:0]      HALF_SQ   = (2*NB)'(1) << (2 * TW);
  localparam logic signed [A-1:0]  PITCH_LIM = A'(1) << (A - 2);

  function automatic logic signed [P-1:0] scaled(input logic signed [W-1:0] a,
                                                 input logic signed [W-1:0] b);
    logic signed [2*W-1:0] m;
    m = a * b;
    return P'(m >>> PROD_SHIFT);
  endfunction

  logic en, accept;
  logic skid_full;
  euler_t skid, pipe_res;
  logic pipe_valid, take;

  // stage 1
  logic signed [P-1:0] p_wx, p_yz, p_xx, p_yy, p_wy, p_zx, p_wz, p_xy, p_zz;
  // stage 2
  logic signed [OW-1:0] roll_y, roll_x, yaw_y, yaw_x, t2;
  // stage 3
  logic signed [OW-1:0] t_neg, t3;
  logic [TW-1:0]        t_abs;
  logic [2*TW-1:0]      tsq3;
  logic                 sat3, pos3;
  // stage 4
  logic [2*NB-1:0]      rad4;
  logic signed [OW-1:0] t4;
  logic                 sat4, pos4;

  logic [NB-1:0]        root;
  logic [OW+1:0]        tside;
  logic signed [OW-1:0] t5;
  logic                 sat5, pos5, sat_o, pos_o;
  logic [A-1:0]         roll_c, yaw_c, pitch_c, roll_d, yaw_d;

  assign en         = !skid_full;
  assign quat_ready = en;
  assign accept     = quat_valid && en;

  always_ff @(posedge clk) begin
    if (en) begin
      p_wx <= scaled(quat.q_w, quat.q_x);
      p_yz <= scaled(quat.q_y, quat.q_z);
      p_xx <= scaled(quat.q_x, quat.q_x);
      p_yy <= scaled(quat.q_y, quat.q_y);
      p_wy <= scaled(quat.q_w, quat.q_y);
      p_zx <= scaled(quat.q_z, quat.q_x);
      p_wz <= scaled(quat.q_w, quat.q_z);
      p_xy <= scaled(quat.q_x, quat.q_y);
      p_zz <= scaled(quat.q_z, quat.q_z);
    end
  end

  // common factor of two dropped from both atan2 operands
  always_ff @(posedge clk) begin
    if (en) begin
      roll_y <= OW'(p_wx) + OW'(p_yz);
      roll_x <= HALF_VAL - (OW'(p_xx) + OW'(p_yy));
      yaw_y  <= OW'(p_wz) + OW'(p_xy);
      yaw_x  <= HALF_VAL - (OW'(p_yy) + OW'(p_zz));
      t2     <= OW'(p_wy) - OW'(p_zx);
    end
  end

  // magnitude only matters when below half, so the low bits suffice
  assign t_neg = -t2;
  assign t_abs = t2[OW-1] ? t_neg[TW-1:0] : t2[TW-1:0];

  always_ff @(posedge clk) begin
    if (en) begin
      tsq3 <= t_abs * t_abs;
      sat3 <= (t2 >= HALF_VAL) || (t_neg >= HALF_VAL);
      pos3 <= (t2 > 0);
      t3   <= t2;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      rad4 <= HALF_SQ - (2*NB)'(tsq3);
      t4   <= t3;
      sat4 <= sat3;
      pos4 <= pos3;
    end
  end

  qte_isqrt #(.ROOT_W(NB)) u_sqrt (
    .clk  (clk),
    .en   (en),
    .rad  (rad4),
    .root (root)
  );

  qte_delay #(.WIDTH(OW + 2), .DEPTH(NB)) u_tside (
    .clk (clk),
    .rst (rst),
    .en  (en),
    .d   ({t4, sat4, pos4}),
    .q   (tside)
  );

  assign t5   = tside[OW+1:2];
  assign sat5 = tside[1];
  assign pos5 = tside[0];

  qte_cordic #(.OPND_W(OW), .ANG_W(A)) u_roll (
    .clk   (clk),
    .en    (en),
    .y_in  (roll_y),
    .x_in  (roll_x),
    .angle (roll_c)
  );

  qte_cordic #(.OPND_W(OW), .ANG_W(A)) u_yaw (
    .clk   (clk),
    .en    (en),
    .y_in  (yaw_y),
    .x_in  (yaw_x),
    .angle (yaw_c)
  );

  qte_cordic #(.OPND_W(OW), .ANG_W(A)) u_pitch (
    .clk   (clk),
    .en    (en),
    .y_in  (t5),
    .x_in  (OW'(root)),
    .angle (pitch_c)
  );

  qte_delay #(.WIDTH(2), .DEPTH(CORDIC_LAT)) u_flags (
    .clk (clk),
    .rst (rst),
    .en  (en),
    .d   ({sat5, pos5}),
    .q   ({sat_o, pos_o})
  );

  // roll and yaw wait for the square root path
  qte_delay #(.WIDTH(2 * A), .DEPTH(ALIGN)) u_align (
    .clk (clk),
    .rst (rst),
    .en  (en),
    .d   ({roll_c, yaw_c}),
    .q   ({roll_d, yaw_d})
  );

  qte_delay #(.WIDTH(1), .DEPTH(PIPE_LAT)) u_vld (
    .clk (clk),
    .rst (rst),
    .en  (en),
    .d   (accept),
    .q   (pipe_valid)
  );

  always_comb begin
    pipe_res.roll_angle = roll_d;
    pipe_res.yaw_angle  = yaw_d;
    if (sat_o) begin
      pipe_res.pitch_angle = pos_o ? PITCH_LIM : -PITCH_LIM;
    end else begin
      pipe_res.pitch_angle = pitch_c;
    end
  end

  assign take = pipe_valid && en;

  // output register with a skid slot behind it
  always_ff @(posedge clk) begin
    if (rst) begin
      euler_valid <= 1'b0;
      skid_full   <= 1'b0;
    end else if (euler_ready || !euler_valid) begin
      if (skid_full) begin
        euler_valid <= 1'b1;
        skid_full   <= 1'b0;
      end else begin
        euler_valid <= take;
      end
    end else if (take) begin
      skid_full <= 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (euler_ready || !euler_valid) begin
      euler <= skid_full ? skid : pipe_res;
    end else if (take) begin
      skid <= pipe_res;
    end
  end

  `QTE_ASSERT_IMP(a_skid_behind_output, skid_full, euler_valid, "skid slot full with output empty")
  `QTE_ASSERT_IMP(a_skid_fill_on_stall, $rose(skid_full), $past(euler_valid && !euler_ready), "skid filled without a stalled transfer")
  `QTE_ASSERT_IMP(a_pitch_range, euler_valid, (euler.pitch_angle <= PITCH_LIM) && (euler.pitch_angle >= -PITCH_LIM), "pitch beyond a quarter turn")

endmodule
